@@ hdl/prom_crc4_check_core_defines.svh @@
// ----------------------------------------------------------------------------
// prom crc-4 check: assertion macros
// shared property shapes for the core's concurrent checks
// ----------------------------------------------------------------------------
`ifndef PROM_CRC4_CHECK_CORE_DEFINES_SVH
`define PROM_CRC4_CHECK_CORE_DEFINES_SVH

// antecedent in this cycle implies consequent in the next
`define PCC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define PCC_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hdl/pcc_pkg.sv @@
// ----------------------------------------------------------------------------
// pcc_pkg
// constants and result codes for the prom crc-4 check
// ----------------------------------------------------------------------------
`default_nettype none

package pcc_pkg;

    localparam int WORD_W  = 16;
    localparam int NIB_W   = 4;
    localparam int CNT_W   = 4;
    localparam int IDX_W   = 3;

    // crc polynomial on the 16-bit remainder
    localparam logic [WORD_W-1:0] CRC_POLY       = 16'h3000;
    // the eighth word keeps only its high byte for hashing
    localparam logic [WORD_W-1:0] LAST_WORD_KEEP = 16'hFF00;
    localparam logic [WORD_W-1:0] WORD_ALL_ZERO  = 16'h0000;
    localparam logic [WORD_W-1:0] WORD_ALL_ONES  = 16'hFFFF;

    localparam logic [IDX_W-1:0] LAST_WORD_IDX  = 3'd7;
    localparam logic [CNT_W-1:0] THRESH_RESET   = 4'd4;
    localparam logic [CNT_W-1:0] MAX_PLAUSIBLE  = 4'd8;

    // bit steps of the shared shifter: one per bit, two bytes per word
    localparam logic [3:0] STEP_HIGH_BYTE = 4'd0;
    localparam logic [3:0] STEP_LOW_BYTE  = 4'd8;
    localparam logic [3:0] STEP_LAST      = 4'd15;

    typedef enum logic [1:0] {
        STATUS_IMPLAUSIBLE = 2'd0,
        STATUS_MISMATCH    = 2'd1,
        STATUS_MATCH       = 2'd2
    } status_t;

endpackage

`default_nettype wire

@@ hdl/prom_crc4_check_core.sv @@
// ----------------------------------------------------------------------------
// prom_crc4_check_core
// plausibility count and crc-4 check over an eight-word calibration image
// ----------------------------------------------------------------------------
// usage
//   a word is transferred on a rising edge with start high and busy low.
//   each word is hashed bit-serially by one shift/xor unit, high byte first,
//   so busy stays high after the transfer while the single shifter steps one
//   crc bit per cycle; a new word is taken only once busy is low again.
//   after the eighth word the result (status, computed_crc, prom_crc,
//   plausible_count) is shown for one cycle with done high; done
//   is registered on the last shift step of that word. the block then starts a
//   new image. there is no back-pressure: the receiver must take the result in
//   that cycle.
//   the user must write min_plausible_words (cfg channel, cfg_ready always
//   high) only while idle; the block does not check it. it resets to four.
//   reset clears the word index, the remainder and the plausible count.
// ----------------------------------------------------------------------------
`default_nettype none

`include "prom_crc4_check_core_defines.svh"

module prom_crc4_check_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // word input
    input  wire logic        start,
    output logic             busy,
    input  wire logic [15:0] prom_word,
    // configuration
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [3:0]  cfg_data,
    // result
    output logic             done,
    output logic [1:0]       status,
    output logic [3:0]       computed_crc,
    output logic [3:0]       prom_crc,
    output logic [3:0]       plausible_count
);

    import pcc_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_SHIFT
    } state_t;

    state_t              state_reg;
    logic [3:0]          step_reg;
    logic [WORD_W-1:0]   word_reg;
    logic [NIB_W-1:0]    stored_reg;
    logic                last_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [WORD_W-1:0]   rem_reg;
    logic [CNT_W-1:0]    plaus_reg;
    logic [CNT_W-1:0]    thresh_reg;
    logic                done_reg;
    status_t             status_reg;
    logic [NIB_W-1:0]    crc_out_reg;
    logic [NIB_W-1:0]    stored_out_reg;
    logic [CNT_W-1:0]    count_out_reg;

    logic                accept;
    logic                is_last;
    logic                plausible;
    logic [7:0]          byte_in;
    logic [WORD_W-1:0]   rem_mix;
    logic [WORD_W-1:0]   rem_next;
    logic [NIB_W-1:0]    crc_now;
    status_t             status_next;

    // handshakes
    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg == ST_SHIFT);
    assign cfg_ready = 1'b1;

    // word classification at transfer
    assign is_last   = (idx_reg == LAST_WORD_IDX);
    assign plausible = (prom_word != WORD_ALL_ZERO) && (prom_word != WORD_ALL_ONES);

    // shared shift/xor unit: a byte enters at the first step of each byte
    always_comb
    begin
        unique case (step_reg)
            STEP_HIGH_BYTE: byte_in = word_reg[15:8];
            STEP_LOW_BYTE:  byte_in = word_reg[7:0];
            default:        byte_in = 8'h00;
        endcase
        rem_mix = rem_reg ^ {8'h00, byte_in};
        if (rem_mix[WORD_W-1])
        begin
            rem_next = {rem_mix[WORD_W-2:0], 1'b0} ^ CRC_POLY;
        end
        else
        begin
            rem_next = {rem_mix[WORD_W-2:0], 1'b0};
        end
    end

    // verdict from the plausible count and the final remainder
    assign crc_now = rem_next[WORD_W-1:WORD_W-NIB_W];
    always_comb
    begin
        priority if (plaus_reg < thresh_reg)
        begin
            status_next = STATUS_IMPLAUSIBLE;
        end
        else if (crc_now == stored_reg)
        begin
            status_next = STATUS_MATCH;
        end
        else
        begin
            status_next = STATUS_MISMATCH;
        end
    end

    // sequencer, working registers and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            word_reg       <= '0;
            stored_reg     <= '0;
            last_reg       <= 1'b0;
            idx_reg        <= '0;
            rem_reg        <= '0;
            plaus_reg      <= '0;
            thresh_reg     <= THRESH_RESET;
            done_reg       <= 1'b0;
            status_reg     <= STATUS_IMPLAUSIBLE;
            crc_out_reg    <= '0;
            stored_out_reg <= '0;
            count_out_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;

            // configuration transfer
            if (cfg_valid && cfg_ready)
            begin
                thresh_reg <= cfg_data;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        word_reg   <= is_last ? (prom_word & LAST_WORD_KEEP) : prom_word;
                        stored_reg <= prom_word[NIB_W-1:0];
                        last_reg   <= is_last;
                        plaus_reg  <= plaus_reg + {3'b000, plausible};
                        step_reg   <= STEP_HIGH_BYTE;
                        state_reg  <= ST_SHIFT;
                    end
                end
                ST_SHIFT:
                begin
                    rem_reg  <= rem_next;
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == STEP_LAST)
                    begin
                        state_reg <= ST_IDLE;
                        if (last_reg)
                        begin
                            done_reg       <= 1'b1;
                            status_reg     <= status_next;
                            crc_out_reg    <= crc_now;
                            stored_out_reg <= stored_reg;
                            count_out_reg  <= plaus_reg;
                            rem_reg        <= '0;
                            plaus_reg      <= '0;
                            idx_reg        <= '0;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 3'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign computed_crc    = crc_out_reg;
    assign prom_crc        = stored_out_reg;
    assign plausible_count = count_out_reg;

    // checks
    `PCC_ASSERT_NEXT(a_result_after_last,
                     busy && (step_reg == STEP_LAST) && last_reg, done,
                     "result missing after eighth word")
    `PCC_ASSERT_NEXT(a_no_stray_result,
                     !(busy && (step_reg == STEP_LAST) && last_reg), !done,
                     "result without eighth word")
    `PCC_ASSERT_NEXT(a_busy_after_start, start && !busy, busy,
                     "transfer did not start the shifter")
    `PCC_ASSERT_SAME(a_count_bounded, done, plausible_count <= MAX_PLAUSIBLE,
                     "plausible count above eight")
    `PCC_ASSERT_SAME(a_idle_after_result, done,
                     !busy && (idx_reg == '0) && (rem_reg == '0),
                     "state not cleared after result")

endmodule

`default_nettype wire
